// ----- rtl/fqrr_pkg.sv -----
// Shared constants, status codes and stage types for the four-queue round-robin drain.
package fqrr_pkg;

  localparam int unsigned NumQueues    = 4;
  localparam int unsigned QueueSelW    = 2;
  localparam int unsigned TagPortW     = 64;
  localparam int unsigned QueueDepthDf = 16;
  localparam int unsigned TagBitsDf    = 64;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_DROP  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  // Decision taken at acceptance, carried alongside the RAM read
  typedef struct packed {
    status_e              status;
    logic [QueueSelW-1:0] queue;
    logic                 deq_hit;
  } fqrr_dec_t;

endpackage

// ----- rtl/fqrr_if.sv -----
// Handshake channel interfaces for requests and results.
interface fqrr_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [1:0]  queue_sel;
  logic [63:0] tag;

  modport source (output valid, output op, output queue_sel, output tag, input ready);
  modport sink   (input valid, input op, input queue_sel, input tag, output ready);
endinterface

interface fqrr_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] out_tag;
  logic [1:0]  out_queue;

  modport source (output valid, output status, output out_tag, output out_queue, input ready);
  modport sink   (input valid, input status, input out_tag, input out_queue, output ready);
endinterface

// ----- rtl/four_queue_round_robin_drain.sv -----
// Top level: four tag queues drained in round-robin order.
//
//   channel  dir  payload                              handshake
//   req_i    in   op, queue_sel, tag                   valid/ready
//   rsp_o    out  status, out_tag, out_queue           valid/ready
//
// One item per cycle while rsp_o.ready keeps the result register free; each
// result passes the registered read of the tag RAM, with the decision stage
// beside it, and then the result register before it is presented.
// Reset clears pointers, fill counts and the service pointer; the tag RAM
// is not cleared, the fill counts guard every read.
// A stalled result holds one further item in the decision stage before
// req_i.ready drops.
module four_queue_round_robin_drain
  import fqrr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDf,
  parameter int unsigned TAG_BITS    = TagBitsDf
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fqrr_req_if.sink   req_i,
  fqrr_rsp_if.source rsp_o
);

  localparam int unsigned IdxW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned AddrW    = QueueSelW + IdxW;
  localparam int unsigned RamDepth = NumQueues << IdxW;

  logic                accept;
  logic                in_ready;
  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  logic [TAG_BITS-1:0] ram_wdata, ram_rdata;
  fqrr_dec_t           dec;

  assign accept      = req_i.valid && in_ready;
  assign req_i.ready = in_ready;

  fqrr_sched #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (req_i.op),
    .queue_sel_i (req_i.queue_sel),
    .tag_i       (req_i.tag),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .dec_o       (dec)
  );

  fqrr_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (RamDepth)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fqrr_outstage #(
    .TAG_BITS (TAG_BITS)
  ) u_outstage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .dec_i       (dec),
    .rdata_i     (ram_rdata),
    .in_ready_o  (in_ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .status_o    (rsp_o.status),
    .out_tag_o   (rsp_o.out_tag),
    .out_queue_o (rsp_o.out_queue)
  );

endmodule

// ----- rtl/fqrr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fqrr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fqrr_sched.sv -----
// Ring pointers, fill counts and round-robin pick for the four queues.
module fqrr_sched
  import fqrr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDf,
  parameter int unsigned TAG_BITS    = TagBitsDf,
  localparam int unsigned IdxW  = $clog2(QUEUE_DEPTH),
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned AddrW = QueueSelW + IdxW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 op_i,
  input  logic [QueueSelW-1:0] queue_sel_i,
  input  logic [TagPortW-1:0]  tag_i,
  output logic                 ram_we_o,
  output logic [AddrW-1:0]     ram_waddr_o,
  output logic [TAG_BITS-1:0]  ram_wdata_o,
  output logic                 ram_re_o,
  output logic [AddrW-1:0]     ram_raddr_o,
  output fqrr_dec_t            dec_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  logic [IdxW-1:0]      head_q [NumQueues];
  logic [IdxW-1:0]      tail_q [NumQueues];
  logic [CntW-1:0]      fill_q [NumQueues];
  logic [QueueSelW-1:0] ptr_q, ptr_d;

  logic                 full_sel;
  logic                 found;
  logic [QueueSelW-1:0] pick;
  logic [QueueSelW-1:0] cand;
  logic                 do_enq, do_deq;

  assign full_sel = (fill_q[queue_sel_i] == FullCnt);

  // First non-empty queue from the service pointer onwards
  always_comb begin
    found = 1'b0;
    pick  = '0;
    cand  = '0;
    for (int k = 0; k < NumQueues; k++) begin
      cand = ptr_q + QueueSelW'(k);
      if (!found && (fill_q[cand] != '0)) begin
        found = 1'b1;
        pick  = cand;
      end
    end
  end

  assign do_enq = accept_i && (op_i == OP_ENQ) && !full_sel;
  assign do_deq = accept_i && (op_i == OP_DEQ) && found;
  assign ptr_d  = pick + QueueSelW'(1);

  assign ram_we_o    = do_enq;
  assign ram_waddr_o = {queue_sel_i, tail_q[queue_sel_i]};
  assign ram_wdata_o = tag_i[TAG_BITS-1:0];
  assign ram_re_o    = do_deq;
  assign ram_raddr_o = {pick, head_q[pick]};

  always_comb begin
    dec_o = '{status: STATUS_DONE, queue: '0, deq_hit: 1'b0};
    if (op_i == OP_ENQ) begin
      if (full_sel) begin
        dec_o.status = STATUS_DROP;
      end
    end else if (found) begin
      dec_o.queue   = pick;
      dec_o.deq_hit = 1'b1;
    end else begin
      dec_o.status = STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      for (int q = 0; q < NumQueues; q++) begin
        head_q[q] <= '0;
        tail_q[q] <= '0;
        fill_q[q] <= '0;
      end
    end else begin
      if (do_enq) begin
        tail_q[queue_sel_i] <= (tail_q[queue_sel_i] == LastIdx) ? '0
                               : tail_q[queue_sel_i] + IdxW'(1);
        fill_q[queue_sel_i] <= fill_q[queue_sel_i] + CntW'(1);
      end
      if (do_deq) begin
        head_q[pick] <= (head_q[pick] == LastIdx) ? '0 : head_q[pick] + IdxW'(1);
        fill_q[pick] <= fill_q[pick] - CntW'(1);
        ptr_q        <= ptr_d;
      end
    end
  end

endmodule

// ----- rtl/fqrr_outstage.sv -----
// Decision stage beside the RAM read, then the result register toward the sink.
module fqrr_outstage
  import fqrr_pkg::*;
#(
  parameter int unsigned TAG_BITS = TagBitsDf
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  fqrr_dec_t            dec_i,
  input  logic [TAG_BITS-1:0]  rdata_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [1:0]           status_o,
  output logic [TagPortW-1:0]  out_tag_o,
  output logic [QueueSelW-1:0] out_queue_o
);

  logic                 s1_valid_q;
  fqrr_dec_t            s1_dec_q;
  logic                 out_valid_q;
  status_e              status_q;
  logic [TagPortW-1:0]  tag_q, tag_d;
  logic [QueueSelW-1:0] queue_q;
  logic                 out_free, s1_move;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_move;

  // RAM read data holds while stalled: no new read without a new item
  always_comb begin
    tag_d = '0;
    if (s1_dec_q.deq_hit) begin
      tag_d[TAG_BITS-1:0] = rdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_dec_q <= dec_i;
    end
    if (s1_move) begin
      status_q <= s1_dec_q.status;
      queue_q  <= s1_dec_q.queue;
      tag_q    <= tag_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_tag_o   = tag_q;
  assign out_queue_o = queue_q;

endmodule
